/* rtl/pfc_pkg.sv */
// Package for the pixel false-color / invert block.
// Widths and fixed-point constants shared by the top level and the scaler.
`default_nettype none

package pfc_pkg;

  localparam int unsigned PIX_W    = 8;
  localparam int unsigned RAMP_W   = 17;  // Q16 ramp value, at most 94587
  localparam int unsigned SCALED_W = 9;   // (ramp * 255) >> 16, at most 368
  localparam int unsigned A_W      = 18;  // signed Q16 a, -9684..55596

  // Q16 luma weights
  localparam logic [14:0] W_RED   = 15'd19595;
  localparam logic [15:0] W_GREEN = 16'd38470;
  localparam logic [12:0] W_BLUE  = 13'd7471;

  localparam logic signed [A_W-1:0] A_OFFSET = 18'sd55596;
  localparam logic signed [A_W-1:0] THIRD1   = 18'sd21845;
  localparam logic signed [A_W-1:0] THIRD2   = 18'sd43691;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

endpackage

`default_nettype wire

/* rtl/pfc_scale.sv */
// Scales a Q16 ramp value by 255: (ramp * 255) >> 16, a 9-bit result of at most 368.
// Depends on pfc_pkg for the ramp and result widths.
`default_nettype none

module pfc_scale (
  input  wire logic [pfc_pkg::RAMP_W-1:0]   ramp,
  output logic      [pfc_pkg::SCALED_W-1:0] scaled
);
  import pfc_pkg::*;

  logic [RAMP_W+7:0] prod;

  // times 255 as shift and subtract
  assign prod   = {ramp, 8'b0} - {8'b0, ramp};
  assign scaled = prod[RAMP_W+7:16];

endmodule

`default_nettype wire

/* rtl/pixel_false_color_or_invert.sv */
// Top level of the pixel false-color / invert block: four-stage pipeline.
// Depends on pfc_pkg and pfc_scale.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, mode, red/green/blue_in | into block
//  out     | out_valid, out_ready, red/green/blue_out    | out of block
//
// One pixel per clock sustained while out_ready is high; each beat is registered
// through the weight products at the edge that takes it, then luma and a, then
// ramps, then scale and fold into the output register.
// Each stage holds its own valid bit and advances when the next one is empty
// or moving, so bubbles collapse and a stall on out_ready loses nothing.
// Reset clears the valid bits only; no result appears until a new beat.
`default_nettype none

module pixel_false_color_or_invert (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       mode,
  input  wire logic [pfc_pkg::PIX_W-1:0]  red_in,
  input  wire logic [pfc_pkg::PIX_W-1:0]  green_in,
  input  wire logic [pfc_pkg::PIX_W-1:0]  blue_in,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic      [pfc_pkg::PIX_W-1:0]  red_out,
  output logic      [pfc_pkg::PIX_W-1:0]  green_out,
  output logic      [pfc_pkg::PIX_W-1:0]  blue_out
);
  import pfc_pkg::*;

  // times three of an 18-bit nonnegative value, known to fit in RAMP_W
  function automatic logic [RAMP_W-1:0] times3(input logic [A_W-1:0] x);
    logic [A_W:0] s;
    s = {x, 1'b0} + {1'b0, x};
    return s[RAMP_W-1:0];
  endfunction

  // triangle ramp of half-width one third around a center
  function automatic logic [RAMP_W-1:0] side_ramp(input logic signed [A_W-1:0] a,
                                                  input logic signed [A_W-1:0] c);
    logic signed [A_W-1:0] d;
    logic signed [A_W-1:0] dabs;
    d    = a - c;
    dabs = d[A_W-1] ? -d : d;
    if (dabs >= THIRD1) begin
      return '0;
    end
    return times3(THIRD1 - dabs);
  endfunction

  // stage valids and advance enables
  logic v1, v2, v3;
  logic adv1, adv2, adv3, adv4;

  assign adv4     = !out_valid || out_ready;
  assign adv3     = !v3 || adv4;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  // stage 1: weight products, inverted pixel
  logic                     mode1;
  logic [3*PIX_W-1:0]       inv1;
  logic [22:0]              prod_r1;
  logic [23:0]              prod_g1;
  logic [20:0]              prod_b1;

  // stage 2: a
  logic                     mode2;
  logic [3*PIX_W-1:0]       inv2;
  logic signed [A_W-1:0]    a2;

  // stage 3: ramps
  logic                     mode3;
  logic [3*PIX_W-1:0]       inv3;
  logic [RAMP_W-1:0]        ramp_r3, ramp_g3, ramp_b3;

  // combinational values between stages
  logic [23:0]              sum2;
  logic signed [A_W-1:0]    a_next;
  logic [RAMP_W-1:0]        ramp_r_next;
  logic [SCALED_W-1:0]      sc_r, sc_g, sc_b;
  logic signed [SCALED_W+1:0] fold_r;
  logic [PIX_W-1:0]         map_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      mode1   <= mode;
      inv1    <= {PIX_MAX - red_in, PIX_MAX - green_in, PIX_MAX - blue_in};
      prod_r1 <= {15'b0, red_in} * {8'b0, W_RED};
      prod_g1 <= {16'b0, green_in} * {8'b0, W_GREEN};
      prod_b1 <= {13'b0, blue_in} * {8'b0, W_BLUE};
    end
  end

  assign sum2   = {1'b0, prod_r1} + prod_g1 + {3'b0, prod_b1};
  assign a_next = A_OFFSET - $signed({2'b0, sum2[23:8]});

  always_ff @(posedge clk) begin
    if (adv2) begin
      mode2 <= mode1;
      inv2  <= inv1;
      a2    <= a_next;
    end
  end

  always_comb begin
    if (a2 <= THIRD1) begin
      ramp_r_next = times3(THIRD1 - a2);
    end else if (a2 >= THIRD2) begin
      ramp_r_next = times3(a2 - THIRD2);
    end else begin
      ramp_r_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      mode3   <= mode2;
      inv3    <= inv2;
      ramp_r3 <= ramp_r_next;
      ramp_g3 <= side_ramp(a2, THIRD1);
      ramp_b3 <= side_ramp(a2, THIRD2);
    end
  end

  pfc_scale u_scale_r (.ramp(ramp_r3), .scaled(sc_r));
  pfc_scale u_scale_g (.ramp(ramp_g3), .scaled(sc_g));
  pfc_scale u_scale_b (.ramp(ramp_b3), .scaled(sc_b));

  // fold red above 255 to 510 - 2r, saturating at zero
  always_comb begin
    fold_r = 11'sd510 - $signed({1'b0, sc_r, 1'b0});
    if (sc_r > SCALED_W'(PIX_MAX)) begin
      map_r = fold_r[SCALED_W+1] ? '0 : fold_r[PIX_W-1:0];
    end else begin
      map_r = sc_r[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      if (mode3) begin
        red_out   <= inv3[3*PIX_W-1:2*PIX_W];
        green_out <= inv3[2*PIX_W-1:PIX_W];
        blue_out  <= inv3[PIX_W-1:0];
      end else begin
        red_out   <= map_r;
        green_out <= sc_g[PIX_W-1:0];
        blue_out  <= sc_b[PIX_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/pfc_checker.sv */
// Port-level checks for pixel_false_color_or_invert, bound to the top level.
// Depends on pfc_pkg for the pixel width.
`default_nettype none

module pfc_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [pfc_pkg::PIX_W-1:0] red_out,
  input wire logic [pfc_pkg::PIX_W-1:0] green_out,
  input wire logic [pfc_pkg::PIX_W-1:0] blue_out
);
  import pfc_pkg::*;

  // reset empties the pipe
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid after reset");

  // back-pressure on the input only when the pipe is full up to the output
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low without output stall");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(red_out) && $stable(green_out) && $stable(blue_out))
    else $error("output beat changed while stalled");

endmodule

bind pixel_false_color_or_invert pfc_checker u_pfc_checker (.*);

`default_nettype wire
